// ===== rtl/register_issue_scoreboard_top_assert.svh =====
// Assertion macros for the register issue scoreboard top level.
// Included by register_issue_scoreboard_top; depends on nothing else.
`ifndef REGISTER_ISSUE_SCOREBOARD_TOP_ASSERT_SVH
`define REGISTER_ISSUE_SCOREBOARD_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RIS_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RIS_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ris_pkg.sv =====
// Shared types and constants of the register issue scoreboard.
// Used by the controller, the datapath and the top level; depends on nothing.
package ris_pkg;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam int IDX_W       = 6;
  localparam int LAT_W       = 4;
  localparam int UNIT_W      = 4;
  localparam int PROD_W      = 5;
  localparam int OUT_COUNT_W = 4;

  localparam logic signed [PROD_W-1:0] PRODUCER_NONE = -5'sd1;

  typedef struct packed {
    logic accept;
    logic commit;
    logic clear_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/register_issue_scoreboard_top.sv =====
// A result is registered when its item commits, once the previous result is taken.
// One item at a time: a table RAM read-modify-write must commit before the next accept.
// Reset: a clearing pass writes all NUM_REGS entries, one per cycle, with item_ready low.
// Top level of the register issue scoreboard; depends on ris_pkg,
// ris_ctrl, ris_datapath and register_issue_scoreboard_top_assert.svh.
module register_issue_scoreboard_top #(
  parameter int NUM_REGS   = 64,
  parameter int CYCLE_BITS = 32,
  parameter int COUNT_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [1:0]                        cmd,
  input  logic [ris_pkg::IDX_W-1:0]         reg_index,
  input  logic [CYCLE_BITS-1:0]             retire_cycle,
  input  logic [CYCLE_BITS-1:0]             now_cycle,
  input  logic [ris_pkg::LAT_W-1:0]         source_latency,
  input  logic [ris_pkg::UNIT_W-1:0]        unit_id,
  input  logic                              unpredictable,
  input  logic                              last_source,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              source_ready,
  output logic                              issue_ok,
  output logic                              verdict_valid,
  output logic [ris_pkg::OUT_COUNT_W-1:0]   pending_after,
  output logic [ris_pkg::OUT_COUNT_W-1:0]   unpredictable_after,
  output logic [CYCLE_BITS-1:0]             return_after,
  output logic signed [ris_pkg::PROD_W-1:0] producer_after,
  output logic                              count_error
);

  ris_pkg::ctrl_cmd_t  ctrl;
  ris_pkg::dp_status_t status;

  ris_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .ctrl       (ctrl)
  );

  ris_datapath #(
    .NUM_REGS   (NUM_REGS),
    .CYCLE_BITS (CYCLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (ctrl),
    .status              (status),
    .cmd                 (cmd),
    .reg_index           (reg_index),
    .retire_cycle        (retire_cycle),
    .now_cycle           (now_cycle),
    .source_latency      (source_latency),
    .unit_id             (unit_id),
    .unpredictable       (unpredictable),
    .last_source         (last_source),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .source_ready        (source_ready),
    .issue_ok            (issue_ok),
    .verdict_valid       (verdict_valid),
    .pending_after       (pending_after),
    .unpredictable_after (unpredictable_after),
    .return_after        (return_after),
    .producer_after      (producer_after),
    .count_error         (count_error)
  );

`include "register_issue_scoreboard_top_assert.svh"

  `RIS_ASSERT_NEXT(a_one_in_flight, clk, rst, item_valid && item_ready, !item_ready, "item accepted while another is in flight")
  `RIS_ASSERT_NOW(a_no_accept_in_clear, clk, rst, ctrl.clear_write, !item_ready, "item ready during clearing pass")
  `RIS_ASSERT_NOW(a_verdict_consistent, clk, rst, result_valid && issue_ok, source_ready && verdict_valid, "issue verdict without ready last source")

endmodule

// ===== rtl/ris_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the scoreboard table; depends on nothing.
module ris_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ris_ctrl.sv =====
// Controller of the register issue scoreboard: clearing pass, accept, commit.
// Depends on ris_pkg for the command and status structs.
module ris_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  ris_pkg::dp_status_t status,
  output ris_pkg::ctrl_cmd_t  ctrl
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state;

  always_comb begin
    ctrl.accept      = item_valid & item_ready;
    ctrl.commit      = (state == S_UPDATE) & status.out_free;
    ctrl.clear_write = (state == S_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      item_ready <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (status.clear_last) begin
            state      <= S_IDLE;
            item_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            state      <= S_UPDATE;
            item_ready <= 1'b0;
          end
        end
        S_UPDATE: begin
          if (status.out_free) begin
            state      <= S_IDLE;
            item_ready <= 1'b1;
          end
        end
        default: begin
          state      <= S_CLEAR;
          item_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/ris_datapath.sv =====
// Datapath of the register issue scoreboard: item latch, table RAM,
// read-modify-write logic, verdict accumulator and result register.
// Depends on ris_pkg and ris_ram.
module ris_datapath #(
  parameter int NUM_REGS   = 64,
  parameter int CYCLE_BITS = 32,
  parameter int COUNT_BITS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ris_pkg::ctrl_cmd_t                     ctrl,
  output ris_pkg::dp_status_t                    status,
  input  logic [1:0]                             cmd,
  input  logic [ris_pkg::IDX_W-1:0]              reg_index,
  input  logic [CYCLE_BITS-1:0]                  retire_cycle,
  input  logic [CYCLE_BITS-1:0]                  now_cycle,
  input  logic [ris_pkg::LAT_W-1:0]              source_latency,
  input  logic [ris_pkg::UNIT_W-1:0]             unit_id,
  input  logic                                   unpredictable,
  input  logic                                   last_source,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic                                   source_ready,
  output logic                                   issue_ok,
  output logic                                   verdict_valid,
  output logic [ris_pkg::OUT_COUNT_W-1:0]        pending_after,
  output logic [ris_pkg::OUT_COUNT_W-1:0]        unpredictable_after,
  output logic [CYCLE_BITS-1:0]                  return_after,
  output logic signed [ris_pkg::PROD_W-1:0]      producer_after,
  output logic                                   count_error
);

  localparam int ADDR_W = $clog2(NUM_REGS);
  localparam int PW     = ris_pkg::PROD_W;
  localparam int WORD_W = 2 * COUNT_BITS + CYCLE_BITS + PW;
  localparam int SUM_W  = CYCLE_BITS + 1;
  localparam int EXT_W  = COUNT_BITS + ris_pkg::OUT_COUNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Item latch.
  ris_pkg::cmd_t                 cmd_q;
  logic                          inside_q;
  logic [ADDR_W-1:0]             addr_q;
  logic [CYCLE_BITS-1:0]         retire_q;
  logic [CYCLE_BITS-1:0]         now_q;
  logic [ris_pkg::LAT_W-1:0]     lat_q;
  logic [ris_pkg::UNIT_W-1:0]    unit_q;
  logic                          unpred_q;
  logic                          last_q;

  logic                          verdict_accum;
  logic [ADDR_W-1:0]             clr_cnt;

  logic [ADDR_W+ris_pkg::IDX_W-1:0] idx_ext;
  logic                          inside_in;
  logic [ADDR_W-1:0]             raddr;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [WORD_W-1:0]             ram_wdata;
  logic [WORD_W-1:0]             ram_rdata;
  logic [WORD_W-1:0]             new_word;
  logic [WORD_W-1:0]             reset_word;

  logic [COUNT_BITS-1:0]         pend_r;
  logic [COUNT_BITS-1:0]         unp_r;
  logic [CYCLE_BITS-1:0]         ret_r;
  logic signed [PW-1:0]          prod_r;

  logic [COUNT_BITS-1:0]         pend_n;
  logic [COUNT_BITS-1:0]         unp_n;
  logic [CYCLE_BITS-1:0]         ret_n;
  logic signed [PW-1:0]          prod_n;
  logic                          err_n;
  logic                          wr_need;

  logic [COUNT_BITS-1:0]         pend_rep;
  logic [COUNT_BITS-1:0]         unp_rep;
  logic [CYCLE_BITS-1:0]         ret_rep;
  logic signed [PW-1:0]          prod_rep;
  logic [EXT_W-1:0]              pend_ext;
  logic [EXT_W-1:0]              unp_ext;

  logic [SUM_W-1:0]              limit;
  logic                          rdy;
  logic                          is_check;
  logic                          acc;

  assign idx_ext   = {{ADDR_W{1'b0}}, reg_index};
  assign inside_in = (32'(reg_index) < 32'(NUM_REGS));
  assign raddr     = inside_in ? idx_ext[ADDR_W-1:0] : '0;

  assign {pend_r, unp_r, ret_r, prod_r} = ram_rdata;
  assign reset_word = {{COUNT_BITS{1'b0}}, {COUNT_BITS{1'b0}}, {CYCLE_BITS{1'b0}},
                       ris_pkg::PRODUCER_NONE};

  always_comb begin
    pend_n  = pend_r;
    unp_n   = unp_r;
    ret_n   = ret_r;
    prod_n  = prod_r;
    err_n   = 1'b0;
    wr_need = 1'b0;
    case (cmd_q)
      ris_pkg::CMD_MARK: begin
        wr_need = 1'b1;
        if (pend_r == COUNT_MAX) begin
          err_n = 1'b1;
        end else begin
          pend_n = pend_r + 1'b1;
        end
        if (unpred_q) begin
          if (unp_r == COUNT_MAX) begin
            err_n = 1'b1;
          end else begin
            unp_n = unp_r + 1'b1;
          end
        end
        ret_n  = retire_q;
        prod_n = {1'b0, unit_q};
      end
      ris_pkg::CMD_CLEAR: begin
        wr_need = 1'b1;
        if (unpred_q) begin
          if (unp_r == '0) begin
            err_n = 1'b1;
          end else begin
            unp_n = unp_r - 1'b1;
          end
        end
        if (pend_r == '0) begin
          err_n = 1'b1;
        end else begin
          pend_n = pend_r - 1'b1;
        end
        if (pend_n == '0) begin
          ret_n  = '0;
          prod_n = ris_pkg::PRODUCER_NONE;
        end
      end
      default: begin
      end
    endcase
    if (!inside_q) begin
      err_n   = 1'b0;
      wr_need = 1'b0;
    end
  end

  assign new_word = {pend_n, unp_n, ret_n, prod_n};

  assign pend_rep = inside_q ? pend_n : '0;
  assign unp_rep  = inside_q ? unp_n : '0;
  assign ret_rep  = inside_q ? ret_n : '0;
  assign prod_rep = inside_q ? prod_n : ris_pkg::PRODUCER_NONE;
  assign pend_ext = {{ris_pkg::OUT_COUNT_W{1'b0}}, pend_rep};
  assign unp_ext  = {{ris_pkg::OUT_COUNT_W{1'b0}}, unp_rep};

  // A source blocks only when its return cycle lies beyond now plus latency.
  assign limit    = {1'b0, now_q} + SUM_W'(lat_q);
  assign rdy      = !inside_q || !({1'b0, ret_rep} > limit);
  assign is_check = (cmd_q == ris_pkg::CMD_CHECK);
  assign acc      = verdict_accum & rdy;

  assign ram_we    = ctrl.clear_write | (ctrl.commit & wr_need);
  assign ram_waddr = ctrl.clear_write ? clr_cnt : addr_q;
  assign ram_wdata = ctrl.clear_write ? reset_word : new_word;

  assign status.clear_last = (clr_cnt == ADDR_W'(NUM_REGS - 1));
  assign status.out_free   = !result_valid || result_ready;

  ris_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_REGS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctrl.accept),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_q    <= ris_pkg::cmd_t'(cmd);
      inside_q <= inside_in;
      addr_q   <= raddr;
      retire_q <= retire_cycle;
      now_q    <= now_cycle;
      lat_q    <= source_latency;
      unit_q   <= unit_id;
      unpred_q <= unpredictable;
      last_q   <= last_source;
    end
    if (ctrl.commit) begin
      source_ready        <= is_check & rdy;
      issue_ok            <= is_check & last_q & acc;
      verdict_valid       <= is_check & last_q;
      pending_after       <= pend_ext[ris_pkg::OUT_COUNT_W-1:0];
      unpredictable_after <= unp_ext[ris_pkg::OUT_COUNT_W-1:0];
      return_after        <= ret_rep;
      producer_after      <= prod_rep;
      count_error         <= err_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      verdict_accum <= 1'b1;
      clr_cnt       <= '0;
    end else begin
      if (ctrl.commit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (ctrl.commit && is_check) begin
        verdict_accum <= last_q ? 1'b1 : acc;
      end
      if (ctrl.clear_write && !status.clear_last) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

endmodule
